// ----- rtl/nds_pkg.sv -----
// Shared types and constants for the tube display scan multiplexer.
package nds_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TUBE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANODE_MAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MASK  = 2'd2;

  localparam logic [7:0] BCD_MAX = 8'd9;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] slot;
    logic [7:0] digit;
  } cmd_t;

  typedef struct packed {
    logic       write_accepted;
    logic       anode_enable;
    logic [2:0] anode_address;
    logic [3:0] cathode_code;
  } res_t;

endpackage

// ----- rtl/nds_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat.
interface nds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nds_digit_mem.sv -----
// Digit store: synchronous memory with per-entry valid bits cleared at reset.
module nds_digit_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : 8'd0;

endmodule

// ----- rtl/nixie_display_scan_multiplexer.sv -----
// Top level: scan sequencer around the digit store, with a registered result beat.
// On the accept cycle an item writes or reads the digit store; the next cycle
// loads the result register. A new item is taken only once the result beat of
// the last one has left.
// Reset is synchronous; it clears the scan state, the drive registers and the
// valid bits of all digit entries, so every digit reads as zero until written.
module nixie_display_scan_multiplexer #(
  parameter int MAX_TUBES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nds_pkg::CFG_DATA_W-1:0] cfg_data,
  nds_stream_if.sink                    cmd,
  nds_stream_if.source                  res
);

  localparam int IDX_W = (MAX_TUBES > 1) ? $clog2(MAX_TUBES) : 1;

  nds_pkg::state_t state;
  nds_pkg::state_t state_next;

  logic [3:0]  tube_count;
  logic [23:0] slot_anode_map;
  logic [7:0]  slot_valid_mask;

  logic        phase_on;
  logic [2:0]  scan_index;
  logic        anode_enable;
  logic [2:0]  anode_address;
  logic [3:0]  cathode_code;
  logic        pend_accepted;
  logic        pend_load;
  logic        res_valid;
  nds_pkg::res_t res_data;

  nds_pkg::cmd_t cmd_beat;
  logic        cmd_fire;
  logic [3:0]  count_eff;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic        wr_ok;
  logic        mem_wr_en;
  logic        mem_rd_en;
  logic [7:0]  mem_rd_data;
  logic [3:0]  cathode_next;

  assign cmd_beat = cmd.data;
  assign cmd_fire = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tube_count      <= 4'd1;
      slot_anode_map  <= '0;
      slot_valid_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nds_pkg::CFG_TUBE_COUNT: tube_count      <= cfg_data[3:0];
        nds_pkg::CFG_ANODE_MAP:  slot_anode_map  <= cfg_data[23:0];
        nds_pkg::CFG_VALID_MASK: slot_valid_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_eff = (32'(tube_count) > MAX_TUBES) ? 4'(MAX_TUBES) : tube_count;
    idx       = (32'(scan_index) < MAX_TUBES) ? scan_index : 3'd0;
    wr_ok     = {4'd0, cmd_beat.slot} < {8'd0, count_eff};
    idx_next  = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if ((k > 32'(idx)) && (k < 32'(count_eff)) && slot_valid_mask[k]) begin
        idx_next = 3'(k);
      end
    end
    cathode_next = cathode_code;
    if (pend_load) begin
      cathode_next = (mem_rd_data <= nds_pkg::BCD_MAX) ? mem_rd_data[3:0] : 4'd0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nds_pkg::ST_IDLE: if (cmd_fire) state_next = nds_pkg::ST_LOAD;
      nds_pkg::ST_LOAD: state_next = nds_pkg::ST_IDLE;
      default: state_next = nds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == nds_pkg::ST_IDLE) && !res_valid;
    mem_wr_en = cmd_fire && cmd_beat.mode && wr_ok;
    mem_rd_en = cmd_fire && !cmd_beat.mode;
    res.valid = res_valid;
    res.data  = res_data;
  end

  nds_digit_mem #(
    .DEPTH (MAX_TUBES),
    .AW    (IDX_W)
  ) u_digit_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (cmd_beat.slot[IDX_W-1:0]),
    .wr_data (cmd_beat.digit),
    .rd_en   (mem_rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nds_pkg::ST_IDLE;
      phase_on      <= 1'b0;
      scan_index    <= 3'd0;
      anode_enable  <= 1'b0;
      anode_address <= 3'd0;
      cathode_code  <= 4'd0;
      pend_accepted <= 1'b0;
      pend_load     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (cmd_fire) begin
        pend_accepted <= cmd_beat.mode && wr_ok;
        pend_load     <= !cmd_beat.mode && !phase_on;
        if (!cmd_beat.mode) begin
          phase_on <= !phase_on;
          if (phase_on) begin
            anode_enable <= 1'b0;
          end else begin
            anode_enable  <= 1'b1;
            anode_address <= slot_anode_map[3*idx +: 3];
            scan_index    <= idx_next;
          end
        end
      end
      if (state == nds_pkg::ST_LOAD) begin
        cathode_code <= cathode_next;
        res_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == nds_pkg::ST_LOAD) begin
      res_data.write_accepted <= pend_accepted;
      res_data.anode_enable   <= anode_enable;
      res_data.anode_address  <= anode_address;
      res_data.cathode_code   <= cathode_next;
    end
  end

endmodule
